>>> rtl/core/lgrs_pkg.sv
// Shared types and constants for the Life generation row step block.
package lgrs_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int GRID_WIDTH_W = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int QUEUE_DEPTH = 3;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NBR_CNT_W = 4;

    localparam logic REG_GRID_WIDTH = 1'b0;
    localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RESET = 7'd64;

    localparam logic [NBR_CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [NBR_CNT_W-1:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] row_cells;
        logic                 bottom_row;
    } in_word_t;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] next_cells;
        logic                 last_of_grid;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        logic above;
        logic middle;
        logic incoming;
    } cell_bits_t;

endpackage

>>> rtl/core/lgrs_cell.sv
// One column cell: holds two row bits and computes both candidate next states.
module lgrs_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  lgrs_pkg::cell_ctl_t ctl,
    input  logic                active,
    input  logic                row_in,
    input  lgrs_pkg::cell_bits_t left,
    input  lgrs_pkg::cell_bits_t right,
    output lgrs_pkg::cell_bits_t own,
    output logic                mid_next,
    output logic                bot_next
);
    import lgrs_pkg::*;

    logic above_reg;
    logic middle_reg;
    logic above_next;
    logic middle_next;
    logic [NBR_CNT_W-1:0] mid_count;
    logic [NBR_CNT_W-1:0] bot_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            above_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end else begin
            above_reg  <= above_next;
            middle_reg <= middle_next;
        end
    end

    always_comb begin
        above_next  = above_reg;
        middle_next = middle_reg;
        if (ctl.clear) begin
            above_next  = 1'b0;
            middle_next = 1'b0;
        end else if (ctl.load) begin
            above_next  = middle_reg;
            middle_next = row_in & active;
        end
    end

    assign own.above    = above_reg & active;
    assign own.middle   = middle_reg & active;
    assign own.incoming = row_in & active;

    // The middle row sees the held row above and the arriving row below.
    assign mid_count = NBR_CNT_W'(left.above) + NBR_CNT_W'(left.middle)
                     + NBR_CNT_W'(left.incoming) + NBR_CNT_W'(right.above)
                     + NBR_CNT_W'(right.middle) + NBR_CNT_W'(right.incoming)
                     + NBR_CNT_W'(own.above) + NBR_CNT_W'(own.incoming);

    // The bottom row sees the middle row above and dead cells below.
    assign bot_count = NBR_CNT_W'(left.middle) + NBR_CNT_W'(left.incoming)
                     + NBR_CNT_W'(right.middle) + NBR_CNT_W'(right.incoming)
                     + NBR_CNT_W'(own.middle);

    assign mid_next = active && ((mid_count == BIRTH_COUNT)
                      || (own.middle && mid_count == SURVIVE_COUNT));
    assign bot_next = active && ((bot_count == BIRTH_COUNT)
                      || (own.incoming && bot_count == SURVIVE_COUNT));

endmodule

>>> rtl/core/lgrs_outq.sv
// Three-word result queue that takes up to two words a cycle while it has room and drains one when m_ready is high.
module lgrs_outq (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [1:0]                            push_cnt,
    input  lgrs_pkg::out_word_t                   push_a,
    input  lgrs_pkg::out_word_t                   push_b,
    output logic                                  room,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output lgrs_pkg::out_word_t                   m_data
);
    import lgrs_pkg::*;

    out_word_t slot_reg [QUEUE_DEPTH];
    out_word_t slot_next [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic [QUEUE_CNT_W-1:0] base;
    logic pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    always_comb begin
        pop  = m_valid && m_ready;
        base = count_reg - QUEUE_CNT_W'(pop);
        if (pop) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            slot_next[2] = slot_reg[2];
        end else begin
            slot_next[0] = slot_reg[0];
            slot_next[1] = slot_reg[1];
            slot_next[2] = slot_reg[2];
        end
        if (push_cnt != 2'd0 && base < QUEUE_CNT_W'(QUEUE_DEPTH)) begin
            slot_next[base[QUEUE_IDX_W-1:0]] = push_a;
        end
        if (push_cnt == 2'd2 && base < QUEUE_CNT_W'(QUEUE_DEPTH - 1)) begin
            slot_next[QUEUE_IDX_W'(base + 1'b1)] = push_b;
        end
        count_next = base + QUEUE_CNT_W'(push_cnt);
    end

    assign room    = count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_data  = slot_reg[0];

    a_push_has_room : assert property (@(posedge aclk) disable iff (!aresetn)
        (push_cnt != 2'd0) |-> (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2)))
        else $error("result queue written without room for two words");

    a_idle_count_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (!pop && push_cnt == 2'd0) |=> $stable(count_reg))
        else $error("result queue count moved without a push or a pop");

    a_count_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue count exceeds its depth");

endmodule

>>> rtl/core/life_generation_row_step.sv
// Top level: one generation of B3/S23 Life over a streamed, bounded grid.
//
// Rows of the grid enter on the s_ channel, top to bottom, one word per row,
// with bottom_row set on the last row. Each row after the first returns one
// word on the m_ channel holding the next generation of the row above it; the
// bottom row returns a further word, flagged last_of_grid, for itself. A
// single-row grid gives one word. Cells outside the grid count as dead.
// The grid_width register (APB byte address 0) sets how many columns are in
// use; columns at or past it read as dead and are returned as zero. Write it
// only while no rows are in flight.
// A row is accepted every cycle while s_ready is high; its words go into the
// result queue and are presented on m_ from there. The column cells compute
// both candidate results in the accept cycle, and a three-word queue holds
// them for the output. A bottom row that follows other rows produces two
// words, and s_ready is low while the queue holds two words or more.
// When m_ready is low the queue fills and s_ready falls; nothing is lost.
// Reset sets the width to 64, empties the held rows and the queue.
module life_generation_row_step (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  lgrs_pkg::in_word_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output lgrs_pkg::out_word_t                   m_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lgrs_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [lgrs_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [lgrs_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import lgrs_pkg::*;

    logic [GRID_WIDTH_W-1:0] grid_width_reg;
    logic                    held_reg;
    logic                    held_next;
    logic                    accept;
    logic                    cfg_write;
    cell_ctl_t               ctl;
    cell_bits_t              own [MAX_WIDTH];
    logic [MAX_WIDTH-1:0]    mid_res;
    logic [MAX_WIDTH-1:0]    bot_res;
    logic [1:0]              push_cnt;
    out_word_t               push_a;
    out_word_t               push_b;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_GRID_WIDTH)
                     ? {{(APB_DATA_W-GRID_WIDTH_W){1'b0}}, grid_width_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg <= GRID_WIDTH_RESET;
        end else if (cfg_write && paddr[2] == REG_GRID_WIDTH) begin
            grid_width_reg <= pwdata[GRID_WIDTH_W-1:0];
        end
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
        end else begin
            held_reg <= held_next;
        end
    end

    always_comb begin
        held_next = held_reg;
        ctl.load  = 1'b0;
        ctl.clear = 1'b0;
        if (accept) begin
            if (s_data.bottom_row) begin
                ctl.clear = 1'b1;
                held_next = 1'b0;
            end else begin
                ctl.load  = 1'b1;
                held_next = 1'b1;
            end
        end
    end

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        cell_bits_t left_bits;
        cell_bits_t right_bits;
        logic       active;

        assign active = GRID_WIDTH_W'(i) < grid_width_reg;

        if (i == 0) begin : g_left_edge
            assign left_bits = '0;
        end else begin : g_left
            assign left_bits = own[i-1];
        end

        if (i == MAX_WIDTH - 1) begin : g_right_edge
            assign right_bits = '0;
        end else begin : g_right
            assign right_bits = own[i+1];
        end

        lgrs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .active   (active),
            .row_in   (s_data.row_cells[i]),
            .left     (left_bits),
            .right    (right_bits),
            .own      (own[i]),
            .mid_next (mid_res[i]),
            .bot_next (bot_res[i])
        );
    end

    always_comb begin
        push_cnt = 2'd0;
        if (accept) begin
            push_cnt = 2'(held_reg) + 2'(s_data.bottom_row);
        end
        push_a.next_cells   = held_reg ? mid_res : bot_res;
        push_a.last_of_grid = !held_reg;
        push_b.next_cells   = bot_res;
        push_b.last_of_grid = 1'b1;
    end

    lgrs_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (push_b),
        .room     (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_row_held_after_body : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.bottom_row) |=> held_reg)
        else $error("no row held after a row that is not the bottom row");

    a_grid_closed_after_bottom : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.bottom_row) |=> !held_reg)
        else $error("row still held after the bottom row");

    a_held_drop_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(held_reg) |-> $past(accept && s_data.bottom_row))
        else $error("held rows released without a bottom row");

endmodule

>>> verif/tb_life_generation_row_step.sv
// Self-checking testbench for the streamed Life generation row step block.
module tb_life_generation_row_step;
    import lgrs_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int REG_RESERVED = 1;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [GRID_WIDTH_W-1:0] width_setting = GRID_WIDTH_RESET;
    logic [MAX_WIDTH-1:0]    upper_row = '0;
    logic [MAX_WIDTH-1:0]    held_row = '0;
    int                      held_count = 0;
    out_word_t               expected_words[$];

    int send_idle_pct = 17;
    int recv_idle_pct = 70;
    int mismatches = 0;
    int rows_sent = 0;
    int grids_sent = 0;
    int words_checked = 0;

    life_generation_row_step dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [MAX_WIDTH-1:0] column_mask(input logic [GRID_WIDTH_W-1:0] width);
        int cols;
        cols = (width > MAX_WIDTH) ? MAX_WIDTH : width;
        if (cols >= 64)
            return '1;
        return (64'd1 << cols) - 64'd1;
    endfunction

    function automatic logic [MAX_WIDTH-1:0] life_next_row(input logic [MAX_WIDTH-1:0] up,
                                                           input logic [MAX_WIDTH-1:0] cur,
                                                           input logic [MAX_WIDTH-1:0] down,
                                                           input logic [MAX_WIDTH-1:0] mask);
        logic [MAX_WIDTH-1:0] res;
        logic [MAX_WIDTH-1:0] u;
        logic [MAX_WIDTH-1:0] c;
        logic [MAX_WIDTH-1:0] d;
        int n;
        res = '0;
        u = up & mask;
        c = cur & mask;
        d = down & mask;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            n = 0;
            for (int k = i - 1; k <= i + 1; k++) begin
                if (k >= 0 && k < MAX_WIDTH) begin
                    n += int'(u[k]) + int'(d[k]);
                    if (k != i)
                        n += int'(c[k]);
                end
            end
            if (n == BIRTH_COUNT || (c[i] && n == SURVIVE_COUNT))
                res[i] = 1'b1;
        end
        return res & mask;
    endfunction

    task automatic advance_generation(input in_word_t w);
        logic [MAX_WIDTH-1:0] mask;
        logic [MAX_WIDTH-1:0] row;
        out_word_t word;
        mask = column_mask(width_setting);
        row = w.row_cells & mask;
        if (held_count != 0) begin
            word.next_cells = life_next_row(upper_row, held_row, row, mask);
            word.last_of_grid = 1'b0;
            expected_words = {expected_words, word};
        end
        if (w.bottom_row) begin
            word.next_cells = life_next_row((held_count != 0) ? held_row : '0, row, '0, mask);
            word.last_of_grid = 1'b1;
            expected_words = {expected_words, word};
            upper_row = '0;
            held_row = '0;
            held_count = 0;
        end else begin
            upper_row = (held_count != 0) ? held_row : '0;
            held_row = row;
            held_count = (held_count != 0) ? 2 : 1;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_data);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (m_data.next_cells !== want.next_cells) begin
                    $display("%0t: next_cells mismatch, expected %h, actual %h",
                             $time, want.next_cells, m_data.next_cells);
                    mismatches++;
                end
                if (m_data.last_of_grid !== want.last_of_grid) begin
                    $display("%0t: last_of_grid mismatch, expected %b, actual %b",
                             $time, want.last_of_grid, m_data.last_of_grid);
                    mismatches++;
                end
                words_checked++;
            end
        end
    end

    task automatic send_row(input logic [MAX_WIDTH-1:0] cells, input logic bottom);
        in_word_t w;
        w.row_cells = cells;
        w.bottom_row = bottom;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_generation(w);
        rows_sent++;
        if (bottom)
            grids_sent++;
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input int index, input logic [APB_DATA_W-1:0] value);
        logic [APB_ADDR_W-1:0] addr;
        addr = APB_ADDR_W'(4 * index);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (index == int'(REG_GRID_WIDTH))
            width_setting = value[GRID_WIDTH_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_grid_width();
        logic [APB_DATA_W-1:0] want;
        want = APB_DATA_W'(width_setting);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= APB_ADDR_W'(4 * int'(REG_GRID_WIDTH));
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            $display("%0t: grid_width readback mismatch, expected %h, actual %h",
                     $time, want, prdata);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_grid_width(input logic [GRID_WIDTH_W-1:0] width);
        apb_write(int'(REG_GRID_WIDTH), APB_DATA_W'(width));
    endtask

    function automatic logic [MAX_WIDTH-1:0] random_row();
        logic [MAX_WIDTH-1:0] a;
        logic [MAX_WIDTH-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2: return a;
            3, 4: return a & b;
            5, 6: return a | b;
            7: return 64'h7 << $urandom_range(0, 61);
            8: return 64'd1 << $urandom_range(0, 63);
            default: return $urandom_range(0, 1) ? '1 : '0;
        endcase
    endfunction

    task automatic test_register_access();
        check_grid_width();
        set_grid_width(7'd64);
        check_grid_width();
    endtask

    task automatic test_single_row_grid();
        send_row('1, 1'b1);
        send_row(64'h8000_0000_0000_0001, 1'b1);
    endtask

    task automatic test_extreme_rows();
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b1);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
    endtask

    task automatic test_oscillator();
        send_row('0, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b0);
        send_row(64'h2, 1'b0);
        send_row('0, 1'b1);
    endtask

    task automatic test_width_change_mid_grid();
        wait_for_drain();
        send_row('1, 1'b0);
        wait_for_drain();
        set_grid_width(7'd10);
        send_row('1, 1'b0);
        wait_for_drain();
        set_grid_width(7'd64);
        send_row('1, 1'b1);
    endtask

    task automatic test_zero_width();
        wait_for_drain();
        set_grid_width(7'd0);
        check_grid_width();
        send_row('1, 1'b0);
        send_row('1, 1'b1);
    endtask

    task automatic test_width_clamp();
        wait_for_drain();
        apb_write(int'(REG_GRID_WIDTH), {8'($urandom_range(1, 255)), 17'h0, 7'd127});
        check_grid_width();
        send_row('1, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b1);
    endtask

    task automatic test_reserved_register();
        wait_for_drain();
        set_grid_width(7'd1);
        apb_write(REG_RESERVED, 32'h0000_0005);
        check_grid_width();
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_for_drain();
        set_grid_width(7'd63);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
    endtask

    task automatic run_grid_phase(input int quota, input logic [GRID_WIDTH_W-1:0] width,
                                  input int s_idle, input int r_idle);
        int sent;
        int height;
        wait_for_drain();
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        set_grid_width(width);
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 19) == 0)
                wait_for_drain();
            height = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            for (int r = 0; r < height; r++)
                send_row(random_row(), r == height - 1);
            sent += height;
        end
    endtask

    task automatic test_random_grids();
        run_grid_phase(275, 7'd64, 17, 70);
        run_grid_phase(275, 7'($urandom_range(2, 63)), 17, 70);
        run_grid_phase(275, 7'd1, 70, 17);
        run_grid_phase(275, 7'd127, 70, 17);
        run_grid_phase(275, 7'd3, 0, 0);
        run_grid_phase(275, 7'($urandom_range(4, 64)), 0, 0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_access();
        test_single_row_grid();
        test_extreme_rows();
        test_oscillator();
        test_width_change_mid_grid();
        test_zero_width();
        test_width_clamp();
        test_reserved_register();
        test_random_grids();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d rows in %0d grids and checked %0d result words.",
                 rows_sent, grids_sent, words_checked);
        $display("Widths from 0 to 127 were used, with stalls on either side and none.");
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Run timed out with %0d words outstanding.", expected_words.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> life_generation_row_step.f
rtl/core/lgrs_pkg.sv
rtl/core/lgrs_cell.sv
rtl/core/lgrs_outq.sv
rtl/core/life_generation_row_step.sv
verif/tb_life_generation_row_step.sv
